### sv/wheel_speed_tachometer_top_defines.svh
// Assertion macros used by the checker file.
`ifndef WHEEL_SPEED_TACHOMETER_TOP_DEFINES_SVH
`define WHEEL_SPEED_TACHOMETER_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define WST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define WST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/wst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wst_pkg;

   localparam int TIME_BITS      = 16;
   localparam int CFG_BITS       = 16;
   localparam int CIRC_BITS      = 12;
   localparam int SPEED_BITS     = 18;
   localparam int INTERVAL_BITS  = 16;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CMP_BITS       = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
   localparam int NUM_BITS       = CIRC_BITS + 6;
   localparam int DIV_BITS       = ((NUM_BITS > TIME_BITS) ? NUM_BITS : TIME_BITS) + 1;
   localparam int STEP_BITS      = $clog2(DIV_BITS);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_INTERVAL  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ZERO_TIMEOUT  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_ZERO_COOLDOWN = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_CIRCUMFERENCE = CSR_INDEX_BITS'(3);

   localparam logic [CFG_BITS-1:0]  RESET_MIN_INTERVAL  = CFG_BITS'(170);
   localparam logic [CFG_BITS-1:0]  RESET_ZERO_TIMEOUT  = CFG_BITS'(10000);
   localparam logic [CFG_BITS-1:0]  RESET_ZERO_COOLDOWN = CFG_BITS'(5000);
   localparam logic [CIRC_BITS-1:0] RESET_CIRCUMFERENCE = CIRC_BITS'(2200);

   localparam logic [INTERVAL_BITS-1:0] INTERVAL_MAX = '1;

   typedef struct packed {
      logic [CFG_BITS-1:0]  min_interval;
      logic [CFG_BITS-1:0]  zero_timeout;
      logic [CFG_BITS-1:0]  zero_cooldown;
      logic [CIRC_BITS-1:0] circumference;
   } cfg_type;

   typedef struct packed {
      logic                 is_zero;
      logic [TIME_BITS-1:0] interval;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

endpackage
`default_nettype wire

### sv/wst_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module wst_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [wst_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [wst_pkg::CFG_BITS-1:0]       csr_wdata,
   output wst_pkg::cfg_type                        cfg
);
   import wst_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MIN_INTERVAL:  cfg_in.min_interval  = csr_wdata;
            REG_ZERO_TIMEOUT:  cfg_in.zero_timeout  = csr_wdata;
            REG_ZERO_COOLDOWN: cfg_in.zero_cooldown = csr_wdata;
            REG_CIRCUMFERENCE: cfg_in.circumference = csr_wdata[CIRC_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_interval  <= RESET_MIN_INTERVAL;
         cfg_ff.zero_timeout  <= RESET_ZERO_TIMEOUT;
         cfg_ff.zero_cooldown <= RESET_ZERO_COOLDOWN;
         cfg_ff.circumference <= RESET_CIRCUMFERENCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### sv/wst_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wst_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_falling_edge,
   input  wire wst_pkg::cfg_type          cfg,
   input  wire wst_pkg::queue_status_type queue_status,
   output logic                           push,
   output wst_pkg::job_type               push_job
);
   import wst_pkg::*;

   logic [TIME_BITS-1:0] since_edge_ff;
   logic [TIME_BITS-1:0] since_edge_in;
   logic [TIME_BITS-1:0] since_zero_ff;
   logic [TIME_BITS-1:0] since_zero_in;
   logic [TIME_BITS-1:0] edge_inc;
   logic [TIME_BITS-1:0] zero_inc;
   logic                 transfer;
   logic                 edge_ok;
   logic                 zero_ok;

   always_comb begin
      edge_inc  = (since_edge_ff == '1) ? since_edge_ff : since_edge_ff + 1'b1;
      zero_inc  = (since_zero_ff == '1) ? since_zero_ff : since_zero_ff + 1'b1;
      req_ready = !queue_status.full;
      transfer  = req_valid && req_ready;
      edge_ok   = req_falling_edge &&
                  (CMP_BITS'(edge_inc) >= CMP_BITS'(cfg.min_interval));
      zero_ok   = !edge_ok &&
                  (CMP_BITS'(edge_inc) > CMP_BITS'(cfg.zero_timeout)) &&
                  (CMP_BITS'(zero_inc) >= CMP_BITS'(cfg.zero_cooldown));
      push              = transfer && (edge_ok || zero_ok);
      push_job.is_zero  = zero_ok;
      push_job.interval = edge_inc;
      since_edge_in     = since_edge_ff;
      since_zero_in     = since_zero_ff;
      if (transfer) begin
         since_edge_in = edge_ok ? '0 : edge_inc;
         since_zero_in = zero_ok ? '0 : zero_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_edge_ff <= '0;
         since_zero_ff <= '0;
      end else begin
         since_edge_ff <= since_edge_in;
         since_zero_ff <= since_zero_in;
      end
   end

endmodule
`default_nettype wire

### sv/wst_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module wst_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire wst_pkg::job_type     push_job,
   input  wire logic                 pop,
   output wst_pkg::job_type          pop_job,
   output wst_pkg::queue_status_type queue_status
);
   import wst_pkg::*;

   localparam logic [QPTR_BITS-1:0]   LAST_PTR  = QPTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QCOUNT_BITS-1:0] FULL_COUNT = QCOUNT_BITS'(QUEUE_DEPTH);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff;
   logic [QCOUNT_BITS-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      pop_job            = entry_ff[rd_ptr_ff];
      queue_status.full  = (count_ff == FULL_COUNT);
      queue_status.empty = (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

### sv/wst_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wst_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wst_pkg::cfg_type                  cfg,
   input  wire wst_pkg::queue_status_type         queue_status,
   input  wire wst_pkg::job_type                  pop_job,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [wst_pkg::SPEED_BITS-1:0]         rsp_speed_tenths_kmh,
   output logic [wst_pkg::INTERVAL_BITS-1:0]      rsp_interval_ms,
   output logic                                   rsp_is_zero_report
);
   import wst_pkg::*;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_BITS - 1);

   back_state_type          state_ff;
   back_state_type          state_in;
   logic [DIV_BITS-1:0]     quo_ff;
   logic [DIV_BITS-1:0]     quo_in;
   logic [TIME_BITS:0]      rem_ff;
   logic [TIME_BITS:0]      rem_in;
   logic [TIME_BITS-1:0]    div_ff;
   logic [STEP_BITS-1:0]    step_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [SPEED_BITS-1:0]   speed_ff;
   logic [INTERVAL_BITS-1:0] interval_ff;
   logic                    zero_ff;

   logic                    out_free;
   logic                    load_zero;
   logic                    load_edge;
   logic                    step_en;
   logic                    emit;
   logic [NUM_BITS-1:0]     num;
   logic [DIV_BITS-1:0]     dividend;
   logic [TIME_BITS:0]      trial;
   logic                    fits;
   logic [CMP_BITS-1:0]     div_wide;
   logic [INTERVAL_BITS-1:0] shown;
   logic [SPEED_BITS-1:0]   speed;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      state_in  = state_ff;
      pop       = 1'b0;
      load_zero = 1'b0;
      load_edge = 1'b0;
      step_en   = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!queue_status.empty) begin
               if (pop_job.is_zero) begin
                  if (out_free) begin
                     pop       = 1'b1;
                     load_zero = 1'b1;
                  end
               end else begin
                  pop       = 1'b1;
                  load_edge = 1'b1;
                  state_in  = BACK_DIVIDE;
               end
            end
         end
         BACK_DIVIDE: begin
            step_en = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      num      = NUM_BITS'({cfg.circumference, 5'b0}) + NUM_BITS'({cfg.circumference, 2'b0});
      dividend = DIV_BITS'(num) + DIV_BITS'(pop_job.interval >> 1);
      trial    = {rem_ff[TIME_BITS-1:0], quo_ff[DIV_BITS-1]};
      fits     = trial >= {1'b0, div_ff};
      rem_in   = fits ? trial - {1'b0, div_ff} : trial;
      quo_in   = {quo_ff[DIV_BITS-2:0], fits};
      div_wide = CMP_BITS'(div_ff);
      shown    = (div_wide > CMP_BITS'(INTERVAL_MAX)) ? INTERVAL_MAX
                                                      : div_wide[INTERVAL_BITS-1:0];
      speed    = (div_ff == '0) ? '0 : quo_ff[SPEED_BITS-1:0];
      rsp_valid_in = rsp_valid_ff;
      if (load_zero || emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_edge) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         div_ff  <= pop_job.interval;
         step_ff <= '0;
      end else if (step_en) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + 1'b1;
      end
      if (load_zero) begin
         speed_ff    <= '0;
         interval_ff <= '0;
         zero_ff     <= 1'b1;
      end else if (emit) begin
         speed_ff    <= speed;
         interval_ff <= shown;
         zero_ff     <= 1'b0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_speed_tenths_kmh = speed_ff;
   assign rsp_interval_ms      = interval_ff;
   assign rsp_is_zero_report   = zero_ff;

endmodule
`default_nettype wire

### sv/wheel_speed_tachometer_top.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_falling_edge (one millisecond tick)
// rsp_      out        rsp_valid/rsp_ready   rsp_speed_tenths_kmh, rsp_interval_ms,
//                                            rsp_is_zero_report
// csr_      in         csr_we                csr_index, csr_wdata
//
// A tick transfer is accepted whenever the two-entry job queue has room.
// An edge report holds the back end while it takes the job, runs the restoring divider (one
// quotient bit per cycle) and loads the result; a zero report skips the divider and is
// loaded straight from the queue once the output is free.
// Synchronous reset restores the register defaults, clears both interval counters and empties the queue.
// A stalled result holds the back end, and the ticks stall once the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module wheel_speed_tachometer_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_falling_edge,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [wst_pkg::SPEED_BITS-1:0]          rsp_speed_tenths_kmh,
   output logic [wst_pkg::INTERVAL_BITS-1:0]       rsp_interval_ms,
   output logic                                    rsp_is_zero_report,
   input  wire logic                               csr_we,
   input  wire logic [wst_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [wst_pkg::CFG_BITS-1:0]       csr_wdata
);
   import wst_pkg::*;

   cfg_type          cfg;
   queue_status_type queue_status;
   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          pop_job;

   wst_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wst_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_falling_edge (req_falling_edge),
      .cfg              (cfg),
      .queue_status     (queue_status),
      .push             (push),
      .push_job         (push_job)
   );

   wst_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_job     (push_job),
      .pop          (pop),
      .pop_job      (pop_job),
      .queue_status (queue_status)
   );

   wst_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .queue_status         (queue_status),
      .pop_job              (pop_job),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_speed_tenths_kmh (rsp_speed_tenths_kmh),
      .rsp_interval_ms      (rsp_interval_ms),
      .rsp_is_zero_report   (rsp_is_zero_report)
   );

endmodule
`default_nettype wire

### sv/wst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "wheel_speed_tachometer_top_defines.svh"
module wst_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [wst_pkg::SPEED_BITS-1:0]     rsp_speed_tenths_kmh,
   input wire logic [wst_pkg::INTERVAL_BITS-1:0]  rsp_interval_ms,
   input wire logic                               rsp_is_zero_report
);

   `WST_ASSERT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped before transfer")
   `WST_ASSERT(a_zero_payload, clock, reset, rsp_valid && rsp_is_zero_report |-> rsp_speed_tenths_kmh == '0 && rsp_interval_ms == '0, "zero report carries a speed or interval")
   `WST_ASSERT(a_edge_interval, clock, reset, rsp_valid && !rsp_is_zero_report |-> rsp_interval_ms != '0, "edge report with empty interval")
   `WST_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result shown straight after reset")

endmodule

bind wheel_speed_tachometer_top wst_checker u_checker (.*);
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import wst_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int SETTLE_TICKS = 64;

   typedef struct packed {
      logic [SPEED_BITS-1:0]    speed;
      logic [INTERVAL_BITS-1:0] interval;
      logic                     zero;
   } speed_report_type;

   class tach_scoreboard;
      logic [CFG_BITS-1:0]  min_interval;
      logic [CFG_BITS-1:0]  zero_timeout;
      logic [CFG_BITS-1:0]  zero_cooldown;
      logic [CIRC_BITS-1:0] circumference;
      logic [TIME_BITS-1:0] since_edge;
      logic [TIME_BITS-1:0] since_zero;
      speed_report_type     pending_reports[$];
      int                   failures;
      int                   checked;

      function new();
         min_interval  = RESET_MIN_INTERVAL;
         zero_timeout  = RESET_ZERO_TIMEOUT;
         zero_cooldown = RESET_ZERO_COOLDOWN;
         circumference = RESET_CIRCUMFERENCE;
         since_edge    = '0;
         since_zero    = '0;
         failures      = 0;
         checked       = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
         case (idx)
            REG_MIN_INTERVAL:  min_interval  = data;
            REG_ZERO_TIMEOUT:  zero_timeout  = data;
            REG_ZERO_COOLDOWN: zero_cooldown = data;
            REG_CIRCUMFERENCE: circumference = data[CIRC_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [SPEED_BITS-1:0] tenths_kmh(logic [TIME_BITS-1:0] period);
         logic [31:0] num;
         if (period == '0) begin
            return '0;
         end
         num = 32'(circumference) * 32'd36;
         return SPEED_BITS'((num + 32'(period) / 2) / 32'(period));
      endfunction

      function void note_tick(logic falling);
         speed_report_type rep;
         if (since_edge != '1) begin
            since_edge = since_edge + 1'b1;
         end
         if (since_zero != '1) begin
            since_zero = since_zero + 1'b1;
         end
         if (falling && since_edge >= min_interval) begin
            rep.speed    = tenths_kmh(since_edge);
            rep.interval = INTERVAL_BITS'(since_edge);
            rep.zero     = 1'b0;
            since_edge   = '0;
            pending_reports.push_back(rep);
         end else if (since_edge > zero_timeout && since_zero >= zero_cooldown) begin
            rep.speed    = '0;
            rep.interval = '0;
            rep.zero     = 1'b1;
            since_zero   = '0;
            pending_reports.push_back(rep);
         end
      endfunction

      function void flag(string what);
         failures++;
         if (failures <= 10) begin
            $display("%s", what);
         end
      endfunction

      function void check_report(logic [SPEED_BITS-1:0] speed,
                                 logic [INTERVAL_BITS-1:0] interval, logic zero);
         speed_report_type want;
         checked++;
         if (pending_reports.size() == 0) begin
            flag($sformatf("report %0d arrived unasked: speed %0d interval %0d zero %0b",
                           checked, speed, interval, zero));
            return;
         end
         want = pending_reports.pop_front();
         if (speed !== want.speed || interval !== want.interval || zero !== want.zero) begin
            flag($sformatf("report %0d: expected speed %0d interval %0d zero %0b, got %0d %0d %0b",
                           checked, want.speed, want.interval, want.zero, speed, interval, zero));
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_falling_edge = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [SPEED_BITS-1:0]     rsp_speed_tenths_kmh;
   logic [INTERVAL_BITS-1:0]  rsp_interval_ms;
   logic                      rsp_is_zero_report;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   logic                      idle_on = 1'b1;
   int                        ready_hold = 0;
   int                        quiet_cycles = 0;
   tach_scoreboard            sb;

   wheel_speed_tachometer_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_falling_edge     (req_falling_edge),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_speed_tenths_kmh (rsp_speed_tenths_kmh),
      .rsp_interval_ms      (rsp_interval_ms),
      .rsp_is_zero_report   (rsp_is_zero_report),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         ready_hold <= $urandom_range(0, 12);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Inputs are noted before results so that a same-edge pair is handled in order.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            sb.note_tick(req_falling_edge);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_report(rsp_speed_tenths_kmh, rsp_interval_ms, rsp_is_zero_report);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_tick(logic falling);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_falling_edge <= falling;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_quiet(int n);
      for (int i = 0; i < n; i++) begin
         send_tick(1'b0);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int edge_pct;
      int circ;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default settings: bounce straight after reset, then an edge exactly at the minimum.
      send_tick(1'b1);
      send_quiet(168);
      send_tick(1'b1);
      send_tick(1'b1);
      settle();

      // Every edge accepted, zero reports on every quiet tick, largest circumference.
      write_reg(REG_MIN_INTERVAL, 16'd0);
      write_reg(REG_ZERO_TIMEOUT, 16'd0);
      write_reg(REG_ZERO_COOLDOWN, 16'd0);
      write_reg(REG_CIRCUMFERENCE, 16'hFFFF);
      repeat (3) send_tick(1'b1);
      send_quiet(2);
      send_tick(1'b1);
      settle();

      // A remainder of exactly one half must round up.
      write_reg(REG_MIN_INTERVAL, 16'd1);
      write_reg(REG_ZERO_TIMEOUT, 16'hFFFF);
      write_reg(REG_CIRCUMFERENCE, {4'($urandom_range(1, 15)), 12'd101});
      write_reg(CSR_INDEX_BITS'($urandom_range(4, 255)), 16'($urandom));
      send_tick(1'b1);
      send_quiet(7);
      send_tick(1'b1);
      send_tick(1'b1);
      settle();
      write_reg(REG_CIRCUMFERENCE, 16'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         if (phase == 5) begin
            idle_on <= 1'b0;
         end
         if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_MIN_INTERVAL, 16'($urandom_range(0, 1)));
         end else begin
            write_reg(REG_MIN_INTERVAL, 16'($urandom_range(2, 25)));
         end
         write_reg(REG_ZERO_TIMEOUT, 16'($urandom_range(0, 50)));
         write_reg(REG_ZERO_COOLDOWN, ($urandom_range(0, 3) == 0) ? 16'd0 :
                                      16'($urandom_range(1, 40)));
         case ($urandom_range(0, 4))
            0: circ = 4095;
            1: circ = $urandom_range(100, 4000);
            default: circ = $urandom_range(0, 4095);
         endcase
         write_reg(REG_CIRCUMFERENCE, {4'($urandom_range(0, 15)), 12'(circ)});
         write_reg(CSR_INDEX_BITS'($urandom_range(4, 255)), 16'($urandom));
         edge_pct = $urandom_range(5, 70);
         for (int i = 0; i < 70; i++) begin
            send_tick($urandom_range(0, 99) < edge_pct);
         end
      end

      settle();
      if (sb.failures == 0 && sb.pending_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/wst_pkg.sv
sv/wst_csr.sv
sv/wst_front.sv
sv/wst_queue.sv
sv/wst_back.sv
sv/wheel_speed_tachometer_top.sv
sv/wst_checker.sv
test/testbench.sv
